// File: rtl/multi_button_debounce_lockout_assert.svh
// Assertion macros used by the debounce lockout top level.
`ifndef MULTI_BUTTON_DEBOUNCE_LOCKOUT_ASSERT_SVH
`define MULTI_BUTTON_DEBOUNCE_LOCKOUT_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define MBDL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define MBDL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mbdl_pkg.sv
// Package with the types and constants of the button debounce lockout block.
package mbdl_pkg;

	localparam int MASK_BITS   = 4;
	localparam int MAX_BUTTONS = 8;
	localparam int STREAK_W    = 8;
	localparam int TIME_W      = 32;
	localparam int COOLDOWN_W  = 16;

	localparam logic [STREAK_W-1:0]   STREAK_MAX     = 8'hFF;
	localparam logic [COOLDOWN_W-1:0] COOLDOWN_RESET = 16'd200;
	localparam logic [STREAK_W-1:0]   STABLE_RESET   = 8'd3;

	// Register index taken from paddr[2].
	localparam logic REG_COOLDOWN = 1'b0;
	localparam logic REG_STABLE   = 1'b1;

	typedef struct packed {
		logic [1:0] button_index;
		logic       press_valid;
	} mbdl_result_t;

	typedef struct packed {
		logic [COOLDOWN_W-1:0] cooldown_ms;
		logic [STREAK_W-1:0]   stable_count;
	} mbdl_cfg_t;

endpackage

// File: rtl/mbdl_regs.sv
// APB register file holding the cooldown and stable count settings.
module mbdl_regs
	import mbdl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output mbdl_cfg_t   cfg
);

	logic [COOLDOWN_W-1:0] cooldown_q;
	logic [STREAK_W-1:0]   stable_q;
	logic                  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q <= COOLDOWN_RESET;
			stable_q   <= STABLE_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_COOLDOWN: cooldown_q <= pwdata[COOLDOWN_W-1:0];
				REG_STABLE:   stable_q   <= pwdata[STREAK_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_COOLDOWN: prdata = {{(32-COOLDOWN_W){1'b0}}, cooldown_q};
			REG_STABLE:   prdata = {{(32-STREAK_W){1'b0}}, stable_q};
			default:      prdata = '0;
		endcase
	end

	assign cfg.cooldown_ms  = cooldown_q;
	assign cfg.stable_count = stable_q;

endmodule

// File: rtl/mbdl_pick.sv
// Streak update, cooldown check and lowest-index press pick for one sample.
module mbdl_pick
	import mbdl_pkg::*;
#(
	parameter int BUTTON_COUNT = 4
) (
	input  logic [MASK_BITS-1:0] pressed_mask,
	input  logic                 quiet,
	input  logic [TIME_W-1:0]    now_ms,
	input  logic [TIME_W-1:0]    last_press_ms,
	input  mbdl_cfg_t            cfg,
	input  logic [STREAK_W-1:0]  streak_in  [BUTTON_COUNT],
	output logic [STREAK_W-1:0]  streak_out [BUTTON_COUNT],
	output mbdl_result_t         result
);

	logic [MAX_BUTTONS-1:0]  mask_ext;
	logic [STREAK_W-1:0]     streak_upd [BUTTON_COUNT];
	logic [BUTTON_COUNT-1:0] qualify;
	logic [BUTTON_COUNT-1:0] sel;
	logic [TIME_W-1:0]       elapsed;
	logic                    cooldown_ok;
	logic                    found;
	logic [1:0]              pick_idx;

	// Buttons beyond the mask width always read as released.
	assign mask_ext    = {{(MAX_BUTTONS-MASK_BITS){1'b0}}, pressed_mask};
	assign elapsed     = now_ms - last_press_ms;
	assign cooldown_ok = elapsed >= {{(TIME_W-COOLDOWN_W){1'b0}}, cfg.cooldown_ms};

	always_comb begin
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			if (quiet && mask_ext[i]) begin
				streak_upd[i] = (streak_in[i] == STREAK_MAX) ? streak_in[i]
					: streak_in[i] + 1'b1;
			end else begin
				streak_upd[i] = '0;
			end
			qualify[i] = streak_upd[i] >= cfg.stable_count;
		end
	end

	// Lowest index wins.
	always_comb begin
		found    = 1'b0;
		pick_idx = '0;
		sel      = '0;
		if (cooldown_ok) begin
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				if (!found && qualify[i]) begin
					found    = 1'b1;
					pick_idx = 2'(i);
					sel[i]   = 1'b1;
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			streak_out[i] = sel[i] ? '0 : streak_upd[i];
		end
	end

	assign result.press_valid  = found;
	assign result.button_index = pick_idx;

endmodule

// File: rtl/multi_button_debounce_lockout.sv
// Top level of the multi-button debouncer with press lockout.
// Path: a sample is captured in the input register, moves into the result register when
// that register has room, and is shown from there as a result beat.
// Throughput: one sample per cycle unless the result stream stalls; the input register and
// the result register form a two-stage pipeline and the streak state is updated as a sample
// leaves the input stage. Reset: arst_n clears streaks and the last press time, restores
// cooldown 200 ms and stable count 3, and empties both stages.
`include "multi_button_debounce_lockout_assert.svh"

module multi_button_debounce_lockout
	import mbdl_pkg::*;
#(
	parameter int BUTTON_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Sample stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // [3:0] pressed_mask, [4] quiet, [36:5] now_ms, rest 0
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // [0] press_valid, [2:1] button_index, rest 0
);

	mbdl_cfg_t cfg;

	mbdl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input stage. It holds one sample until the result register has room for it.
	logic                 valid_s1;
	logic [MASK_BITS-1:0] mask_s1;
	logic                 quiet_s1;
	logic [TIME_W-1:0]    now_s1;
	logic                 advance;

	// Result register, which lets the input stage take one more sample while a result waits.
	logic                 out_valid_q;
	mbdl_result_t         out_result_q;

	// Debounce state, advanced only when a sample moves into the result register.
	logic [STREAK_W-1:0]  streak_q   [BUTTON_COUNT];
	logic [STREAK_W-1:0]  streak_nxt [BUTTON_COUNT];
	logic [TIME_W-1:0]    last_press_q;
	mbdl_result_t         result;
	logic                 streak_any;
	logic                 take_press;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			mask_s1  <= s_axis_tdata[3:0];
			quiet_s1 <= s_axis_tdata[4];
			now_s1   <= s_axis_tdata[36:5];
		end
	end

	mbdl_pick #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_pick (
		.pressed_mask  (mask_s1),
		.quiet         (quiet_s1),
		.now_ms        (now_s1),
		.last_press_ms (last_press_q),
		.cfg           (cfg),
		.streak_in     (streak_q),
		.streak_out    (streak_nxt),
		.result        (result)
	);

	// Streaks and the press time are control state: reset clears them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				streak_q[i] <= '0;
			end
			last_press_q <= '0;
		end else if (advance) begin
			streak_q <= streak_nxt;
			if (result.press_valid) begin
				last_press_q <= now_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_result_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_result_q.button_index, out_result_q.press_valid};

	always_comb begin
		streak_any = 1'b0;
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			streak_any = streak_any || (streak_q[i] != '0);
		end
	end

	assign take_press = advance && result.press_valid;

	`MBDL_ASSERT_NEXT(a_press_time, take_press, last_press_q == $past(now_s1), "press time lost")
	`MBDL_ASSERT_NEXT(a_time_hold, !advance, $stable(last_press_q), "press time moved")
	`MBDL_ASSERT_NEXT(a_loud_clear, advance && !quiet_s1, !streak_any, "streaks not cleared")
	`MBDL_ASSERT_NOW(a_empty_ready, !out_valid_q, s_axis_tready, "input stalled while empty")

endmodule

// File: tb/multi_button_debounce_lockout_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the multi-button debouncer with press lockout.
module multi_button_debounce_lockout_tb
	import mbdl_pkg::*;
();

	localparam int BUTTONS = 4;

	// Byte addresses of the two registers; paddr[2] selects the register.
	localparam logic [2:0] ADDR_COOLDOWN = {REG_COOLDOWN, 2'b00};
	localparam logic [2:0] ADDR_STABLE   = {REG_STABLE, 2'b00};

	// Receiver back-pressure styles, switched at random.
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_MOSTLY
	} rx_mode_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // [3:0] pressed_mask, [4] quiet, [36:5] now_ms, rest 0
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [0] press_valid, [2:1] button_index, rest 0

	multi_button_debounce_lockout #(
		.BUTTON_COUNT(BUTTONS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always #1 clk = ~clk;

	// The run is cut off long after the slowest legal run would have ended.
	initial begin
		#500000;
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Debounce predictor. It keeps its own copy of the register settings,
	// the per-button pressed streaks and the time of the last accepted
	// press, and computes the result beat that every sample beat causes.
	// ------------------------------------------------------------------
	logic [COOLDOWN_W-1:0]              lockout_ms     = COOLDOWN_RESET;
	logic [STREAK_W-1:0]                press_thr      = STABLE_RESET;
	logic [BUTTONS-1:0][STREAK_W-1:0]   run_len        = '0;
	logic [TIME_W-1:0]                  last_accept_ms = '0;

	mbdl_result_t predicted_presses[$];

	int fail_count   = 0;
	int samples_sent = 0;
	int presses_seen = 0;
	int writes_done  = 0;

	function automatic mbdl_result_t debounce_step(input logic [MASK_BITS-1:0] mask,
			input logic quiet, input logic [TIME_W-1:0] now);
		mbdl_result_t      res;
		logic [TIME_W-1:0] since;
		res = '0;
		// A button extends its streak only while it reads pressed during a
		// quiet sample; anything else starts it over from zero.
		for (int i = 0; i < BUTTONS; i++) begin
			if (quiet && mask[i]) begin
				if (run_len[i] != STREAK_MAX)
					run_len[i] = run_len[i] + 1'b1;
			end else begin
				run_len[i] = '0;
			end
		end
		// The lockout window is measured with 32-bit wrap, so a timestamp that
		// rolled over still counts forward from the last press.
		since = now - last_accept_ms;
		if (since >= TIME_W'(lockout_ms)) begin
			for (int i = 0; i < BUTTONS; i++) begin
				if (!res.press_valid && run_len[i] >= press_thr) begin
					last_accept_ms   = now;
					run_len[i]       = '0;
					res.press_valid  = 1'b1;
					res.button_index = 2'(i);
				end
			end
		end
		return res;
	endfunction

	function automatic void flag_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endfunction

	// ------------------------------------------------------------------
	// Result checker. Both handshakes are observed on the same rising edge
	// in one process, so the order of prediction and comparison is fixed.
	// A result beat is compared before the sample beat of the same edge is predicted;
	// a sample waits in the input register first, so the two never belong together.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		mbdl_result_t got;
		mbdl_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = mbdl_result_t'(m_axis_tdata[2:0]);
			if (predicted_presses.size() == 0) begin
				flag_failure($sformatf("result beat %b with no sample pending", m_axis_tdata));
			end else begin
				want = predicted_presses.pop_front();
				if (got.press_valid !== want.press_valid
						|| got.button_index !== want.button_index)
					flag_failure($sformatf("press_valid exp %b got %b, button_index exp %0d got %0d",
						want.press_valid, got.press_valid, want.button_index, got.button_index));
				if (want.press_valid)
					presses_seen++;
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready)
			predicted_presses.push_back(debounce_step(s_axis_tdata[3:0], s_axis_tdata[4],
				s_axis_tdata[36:5]));
	end

	// ------------------------------------------------------------------
	// Receiver: each style holds for a random stretch, so there are long
	// runs with no stall next to dense and sparse back-pressure.
	// ------------------------------------------------------------------
	rx_mode_e rx_mode = RX_OPEN;
	int       rx_left = 0;

	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 96);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:   m_axis_tready <= 1'b1;
			RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_axis_tready <= (rx_left % 4 == 0);
			default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// ------------------------------------------------------------------
	// Sender. Beats go out in bursts of random length; between bursts valid
	// either drops for a random gap or stays high. Within a burst valid stays high
	// from beat to beat. Every task below starts and ends at a falling edge.
	// ------------------------------------------------------------------
	int            burst_left = 0;
	logic [31:0]   cur_ms;

	task automatic send_sample(input logic [3:0] mask, input logic quiet,
			input logic [31:0] now);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, now, quiet, mask};
		forever begin
			@(posedge clk);
			if (s_axis_tready)
				break;
		end
		samples_sent++;
		@(negedge clk);
	endtask

	// Stop sending and wait until every predicted result beat has arrived.
	// Every sample yields a result, so an empty prediction queue means nothing is in flight.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		forever begin
			@(negedge clk);
			if (predicted_presses.size() == 0)
				break;
		end
		repeat (3) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready, then idle.
	task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		forever begin
			@(posedge clk);
			if (pready)
				break;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (addr)
			ADDR_COOLDOWN: lockout_ms = value[COOLDOWN_W-1:0];
			ADDR_STABLE:   press_thr  = value[STREAK_W-1:0];
			default: ;
		endcase
		writes_done++;
		@(negedge clk);
	endtask

	// Registers only change while the block holds nothing in flight.
	task automatic set_config(input logic [31:0] cooldown_word, input logic [31:0] stable_word);
		drain_results();
		write_reg(ADDR_COOLDOWN, cooldown_word);
		write_reg(ADDR_STABLE, stable_word);
	endtask

	// ------------------------------------------------------------------
	// Test: reset settings, single buttons, priority, loud samples forcing the
	// streaks clear, zero lockout, zero threshold and timestamp wrap.
	// ------------------------------------------------------------------
	task automatic test_directed_cases();
		// Reset settings: 200 ms lockout, three samples to qualify.
		send_sample(4'hF, 1'b0, 32'd0);
		send_sample(4'hA, 1'b1, 32'd10);
		send_sample(4'hA, 1'b1, 32'd20);
		send_sample(4'hA, 1'b1, 32'd30);
		send_sample(4'hA, 1'b1, 32'd199);   // qualified, but the window has not elapsed
		send_sample(4'hA, 1'b1, 32'd200);   // window elapsed, lowest pressed button wins
		send_sample(4'h8, 1'b1, 32'd201);   // inside the new window
		send_sample(4'h8, 1'b1, 32'd400);
		send_sample(4'h0, 1'b1, 32'hFFFF_FFFF);

		// No lockout and a threshold of one: the lowest pressed button fires on each quiet sample.
		set_config(32'd0, 32'd1);
		send_sample(4'h1, 1'b1, 32'h8000_0000);
		send_sample(4'h2, 1'b1, 32'd0);
		send_sample(4'h4, 1'b1, 32'd0);
		send_sample(4'h8, 1'b1, 32'hFFFF_FFFF);
		send_sample(4'hF, 1'b0, 32'd5);
		send_sample(4'hF, 1'b1, 32'd5);
		send_sample(4'hF, 1'b1, 32'd5);

		// Longest lockout and a zero threshold, written with junk in the upper
		// bits: button 0 fires even when nothing is pressed.
		set_config(32'hABCD_FFFF, 32'h1234_5600);
		send_sample(4'h0, 1'b0, 32'd65538);
		send_sample(4'h0, 1'b0, 32'hFFFF_FFF0);
		send_sample(4'h0, 1'b1, 32'h0000_FFEE);   // one short of the window across the wrap
		send_sample(4'h0, 1'b1, 32'h0000_FFEF);
	endtask

	// ------------------------------------------------------------------
	// Test: all buttons held far past 255 samples while the lockout blocks,
	// so the streaks must saturate rather than wrap back below the threshold.
	// ------------------------------------------------------------------
	task automatic test_streak_saturation();
		logic [31:0] base;
		set_config(32'h0000_FFFF, 32'd255);
		base = last_accept_ms;
		repeat (300)
			send_sample(4'hF, 1'b1, base + $urandom_range(0, 65534));
		send_sample(4'hF, 1'b1, base + 32'd65535);
		send_sample(4'hF, 1'b1, base + 32'd131070);
		send_sample(4'h0, 1'b1, base + 32'd200000);
	endtask

	// ------------------------------------------------------------------
	// Test: random press sequences. Most are a button set held for about
	// the threshold with time creeping forward; the rest are noise with
	// random levels, quiet flags and timestamps anywhere in the 32-bit range.
	// ------------------------------------------------------------------
	task automatic test_random_presses(input int count);
		int          stop_at;
		int          hold;
		logic [3:0]  held;
		logic [31:0] cd_word;
		logic [31:0] thr_word;
		stop_at = samples_sent + count;
		cur_ms  = $urandom;
		while (samples_sent < stop_at) begin
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 5))
					0:       cd_word = 32'd0;
					1:       cd_word = 32'h0000_FFFF;
					2:       cd_word = $urandom;
					default: cd_word = $urandom_range(0, 60);
				endcase
				case ($urandom_range(0, 9))
					0:       thr_word = 32'd0;
					1:       thr_word = 32'd255;
					2:       thr_word = $urandom;
					default: thr_word = $urandom_range(1, 5);
				endcase
				set_config(cd_word, thr_word);
			end
			if ($urandom_range(0, 4) != 0) begin
				held = 4'($urandom_range(1, 15));
				hold = $urandom_range(1, (press_thr > 8) ? 12 : press_thr + 3);
				for (int k = 0; k < hold; k++) begin
					cur_ms += $urandom_range(0, 40);
					// An occasional bounce or loud sample breaks the streak.
					send_sample(($urandom_range(0, 9) == 0) ? 4'($urandom) : held,
						$urandom_range(0, 19) != 0, cur_ms);
				end
				repeat ($urandom_range(1, 3)) begin
					cur_ms += $urandom_range(0, 40);
					send_sample(4'h0, 1'($urandom), cur_ms);
				end
			end else begin
				repeat ($urandom_range(1, 6))
					send_sample(4'($urandom), 1'($urandom),
						$urandom_range(0, 1) ? $urandom : cur_ms + $urandom_range(0, 400));
			end
			// Now and then the sender holds off until the pipeline is empty.
			if ($urandom_range(0, 24) == 0)
				drain_results();
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_streak_saturation();
		test_random_presses(330);

		drain_results();
		repeat (8) @(posedge clk);
		if (predicted_presses.size() != 0)
			flag_failure($sformatf("%0d result beats never arrived", predicted_presses.size()));

		$display("Covered %0d samples and %0d accepted presses over %0d register writes,",
			samples_sent, presses_seen, writes_done);
		$display("including saturated streaks, zero threshold and lockout across timestamp wrap.");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/mbdl_pkg.sv
rtl/mbdl_regs.sv
rtl/mbdl_pick.sv
rtl/multi_button_debounce_lockout.sv
tb/multi_button_debounce_lockout_tb.sv
